### hw/rtl/rowf_pkg.sv
// rowf_pkg: shared constants and types for the rank-order window filter.
// Used by every module under hw/rtl; depends on nothing.

package rowf_pkg;

	localparam int PIX_W          = 8;
	localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

	localparam int WINDOW_DEF     = 3;
	localparam int MAX_WIDTH_DEF  = 2048;
	localparam int MAX_HEIGHT     = 2048;
	localparam int ROW_W          = $clog2(MAX_HEIGHT);

	// configuration port
	localparam int CFG_DATA_W     = 12;
	localparam int CFG_IDX_W      = 2;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RANK_SELECT  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE  = 2'd3;

	localparam logic [11:0] LINE_WIDTH_RST   = 12'd640;
	localparam logic [11:0] FRAME_HEIGHT_RST = 12'd480;
	localparam logic [3:0]  RANK_SELECT_RST  = 4'd4;
	localparam logic        FILTER_MODE_RST  = 1'b0;

	localparam logic MODE_RANK      = 1'b0;
	localparam logic MODE_THRESHOLD = 1'b1;

	// result queue depth; bounds the number of results in flight
	localparam int FIFO_DEPTH     = 8;

	// per-beat tag carried down the pipe
	typedef struct packed {
		logic keep;       // window is interior, beat yields a result
		logic frame_end;  // last interior result of the frame
	} rowf_tag_t;

	typedef struct packed {
		logic [PIX_W-1:0] value;
		logic             frame_end;
	} rowf_res_t;

endpackage

### hw/rtl/rowf_line_store.sv
// rowf_line_store: column-organized line memory, one lane per window row.
// Writes the incoming pixel into its row lane and returns the full column,
// oldest row first, in the following cycle. Depends on rowf_pkg.

module rowf_line_store #(
	parameter int WINDOW    = rowf_pkg::WINDOW_DEF,
	parameter int MAX_WIDTH = rowf_pkg::MAX_WIDTH_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     acc,
	input  logic [$clog2(MAX_WIDTH)-1:0]             addr,
	input  logic [$clog2(WINDOW)-1:0]                slot,
	input  logic [rowf_pkg::PIX_W-1:0]               pix,
	input  rowf_pkg::rowf_tag_t                      tag,
	output logic                                     col_valid,
	output logic [WINDOW-1:0][rowf_pkg::PIX_W-1:0]   col_vec,
	output rowf_pkg::rowf_tag_t                      col_tag
);

	localparam int SLOT_W = $clog2(WINDOW);
	localparam int SUM_W  = $clog2(2 * WINDOW);

	logic [WINDOW-1:0][rowf_pkg::PIX_W-1:0] mem [MAX_WIDTH];

	logic [WINDOW-1:0][rowf_pkg::PIX_W-1:0] rd_s1;
	logic [SLOT_W-1:0]                      slot_s1;
	logic [rowf_pkg::PIX_W-1:0]             pix_s1;
	rowf_pkg::rowf_tag_t                    tag_s1;
	logic                                   valid_s1;
	logic [WINDOW-1:0][rowf_pkg::PIX_W-1:0] word;
	logic [SUM_W-1:0]                       lane_sum [WINDOW];
	logic [SLOT_W-1:0]                      lane_idx [WINDOW];

	// one lane write and one word read per beat
	always_ff @(posedge clk) begin
		if (acc) begin
			mem[addr][slot] <= pix;
			rd_s1           <= mem[addr];
			slot_s1         <= slot;
			pix_s1          <= pix;
			tag_s1          <= tag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= acc;
		end
	end

	// read returned pre-write contents: patch in this beat's own lane
	always_comb begin
		word          = rd_s1;
		word[slot_s1] = pix_s1;
	end

	// lane of window row dr is (slot + 1 + dr) mod WINDOW
	always_comb begin
		for (int dr = 0; dr < WINDOW; dr++) begin
			lane_sum[dr] = SUM_W'(slot_s1) + SUM_W'(dr) + SUM_W'(1);
			if (lane_sum[dr] >= SUM_W'(WINDOW))
				lane_sum[dr] = lane_sum[dr] - SUM_W'(WINDOW);
			lane_idx[dr] = lane_sum[dr][SLOT_W-1:0];
			col_vec[dr]  = word[lane_idx[dr]];
		end
	end

	assign col_valid = valid_s1;
	assign col_tag   = tag_s1;

endmodule

### hw/rtl/rowf_rank_unit.sv
// rowf_rank_unit: window registers, rank counting network and selection.
// Counts each element's position among the window values, then picks the
// element at the requested rank. Depends on rowf_pkg.

module rowf_rank_unit #(
	parameter int WINDOW = rowf_pkg::WINDOW_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     col_valid,
	input  logic [WINDOW-1:0][rowf_pkg::PIX_W-1:0]   col_vec,
	input  rowf_pkg::rowf_tag_t                      col_tag,
	input  logic [$clog2(WINDOW*WINDOW)-1:0]         rank_eff,
	input  logic                                     mode,
	output logic                                     res_valid,
	output rowf_pkg::rowf_res_t                      res
);

	localparam int N    = WINDOW * WINDOW;
	localparam int RK_W = $clog2(N);
	localparam int MID  = WINDOW / 2;

	// win_q[c][r]: column c (0 = leftmost), row r (0 = top)
	logic [WINDOW-1:0][WINDOW-1:0][rowf_pkg::PIX_W-1:0] win_q;
	logic                                               valid_s2;
	logic                                               fe_s2;

	logic [N-1:0][rowf_pkg::PIX_W-1:0] vals;
	logic [RK_W-1:0]                   rank_d [N];

	logic [RK_W-1:0]                   rank_s3 [N];
	logic [N-1:0][rowf_pkg::PIX_W-1:0] vals_s3;
	logic [rowf_pkg::PIX_W-1:0]        centre_s3;
	logic                              fe_s3;
	logic                              valid_s3;

	logic [rowf_pkg::PIX_W-1:0]        ranked;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q    <= '0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (col_valid) begin
				for (int c = 0; c < WINDOW - 1; c++)
					win_q[c] <= win_q[c+1];
				win_q[WINDOW-1] <= col_vec;
			end
			valid_s2 <= col_valid && col_tag.keep;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (col_valid)
			fe_s2 <= col_tag.frame_end;
	end

	assign vals = win_q;

	// position of element i: smaller values, plus equal values at lower index
	always_comb begin
		for (int i = 0; i < N; i++) begin
			rank_d[i] = '0;
			for (int j = 0; j < N; j++) begin
				if ((vals[j] < vals[i]) || ((j < i) && (vals[j] == vals[i])))
					rank_d[i] = rank_d[i] + RK_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			for (int i = 0; i < N; i++)
				rank_s3[i] <= rank_d[i];
			vals_s3   <= vals;
			centre_s3 <= win_q[MID][MID];
			fe_s3     <= fe_s2;
		end
	end

	// positions are a permutation, so exactly one element matches
	always_comb begin
		ranked = '0;
		for (int i = 0; i < N; i++) begin
			if (rank_s3[i] == rank_eff)
				ranked = ranked | vals_s3[i];
		end
	end

	always_comb begin
		res.frame_end = fe_s3;
		if (mode == rowf_pkg::MODE_THRESHOLD)
			res.value = (centre_s3 > ranked) ? rowf_pkg::PIX_MAX : '0;
		else
			res.value = ranked;
	end

	assign res_valid = valid_s3;

endmodule

### hw/rtl/rowf_out_fifo.sv
// rowf_out_fifo: result queue between the rank pipe and the output channel.
// Never sees a push when full; the top level reserves a slot per result.
// Depends on rowf_pkg.

module rowf_out_fifo #(
	parameter int DEPTH = rowf_pkg::FIFO_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  rowf_pkg::rowf_res_t push_data,
	input  logic                pop,
	output logic                not_empty,
	output rowf_pkg::rowf_res_t head
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	rowf_pkg::rowf_res_t mem [DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [CNT_W-1:0]    count_q;

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	assign not_empty = (count_q != '0);
	assign head      = mem[rd_ptr_q];

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q != CNT_W'(DEPTH)))
		else $error("result queue written while full");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("result queue count out of range");
`endif

endmodule

### hw/rtl/rank_order_window_filter_core.sv
// rank_order_window_filter_core: top level of the rank-order window filter.
// Instantiates rowf_line_store, rowf_rank_unit and rowf_out_fifo; uses rowf_pkg.

// Streaming WINDOW x WINDOW rank-order filter for 8-bit grey pixels in raster
// order. Takes one pixel per clock. The result of the window a pixel completes
// (its bottom-right one) passes the line-store read, window and rank registers
// and the result queue to the output channel. The column line memory sets the
// pace with one lane write and one column read per beat. Border pixels and
// windows that do not fit the frame give no result. frame_start restarts the
// row and column counters at that pixel; without it the counters wrap after
// the last pixel of a frame. The line memory is not cleared at reset. Up to
// eight results queue while the output stalls; past that, input stalls.

module rank_order_window_filter_core #(
	parameter int WINDOW    = rowf_pkg::WINDOW_DEF,
	parameter int MAX_WIDTH = rowf_pkg::MAX_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [rowf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rowf_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [rowf_pkg::PIX_W-1:0]         pixel,
	input  logic                               frame_start,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [rowf_pkg::PIX_W-1:0]         value,
	output logic                               frame_end
);

	localparam int N      = WINDOW * WINDOW;
	localparam int RK_W   = $clog2(N);
	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = rowf_pkg::ROW_W;
	localparam int SLOT_W = $clog2(WINDOW);
	localparam int LIM_W  = (COL_W + 1 > 12) ? COL_W + 1 : 12;
	localparam int RES_W  = $clog2(rowf_pkg::FIFO_DEPTH + 1);

	logic [11:0]       line_width_q;
	logic [11:0]       frame_height_q;
	logic [3:0]        rank_select_q;
	logic              filter_mode_q;

	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [SLOT_W-1:0] slot_q;
	logic [RES_W-1:0]  reserved_q;

	logic              acc;
	logic              pop;
	logic [LIM_W-1:0]  lw_ext;
	logic [LIM_W-1:0]  w_eff;
	logic [11:0]       h_eff;
	logic [RK_W-1:0]   rank_eff;

	logic [COL_W-1:0]  cur_col;
	logic [ROW_W-1:0]  cur_row;
	logic [SLOT_W-1:0] cur_slot;
	logic [LIM_W-1:0]  col_inc;
	logic [11:0]       row_inc;
	logic              col_wrap;
	logic              row_wrap;
	rowf_pkg::rowf_tag_t tag;

	logic                                   col_valid;
	logic [WINDOW-1:0][rowf_pkg::PIX_W-1:0] col_vec;
	rowf_pkg::rowf_tag_t                    col_tag;
	logic                                   res_valid;
	rowf_pkg::rowf_res_t                    res;
	rowf_pkg::rowf_res_t                    head;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q   <= rowf_pkg::LINE_WIDTH_RST;
			frame_height_q <= rowf_pkg::FRAME_HEIGHT_RST;
			rank_select_q  <= rowf_pkg::RANK_SELECT_RST;
			filter_mode_q  <= rowf_pkg::FILTER_MODE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				rowf_pkg::REG_LINE_WIDTH:   line_width_q   <= cfg_data;
				rowf_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				rowf_pkg::REG_RANK_SELECT:  rank_select_q  <= cfg_data[3:0];
				rowf_pkg::REG_FILTER_MODE:  filter_mode_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// clamped geometry and rank
	always_comb begin
		lw_ext = LIM_W'(line_width_q);
		if (lw_ext == '0)
			w_eff = LIM_W'(1);
		else if (lw_ext > LIM_W'(MAX_WIDTH))
			w_eff = LIM_W'(MAX_WIDTH);
		else
			w_eff = lw_ext;

		if (frame_height_q == '0)
			h_eff = 12'd1;
		else if (frame_height_q > 12'(rowf_pkg::MAX_HEIGHT))
			h_eff = 12'(rowf_pkg::MAX_HEIGHT);
		else
			h_eff = frame_height_q;

		rank_eff = (32'(rank_select_q) > N - 1) ? RK_W'(N - 1) : RK_W'(rank_select_q);
	end

	assign in_stall = (reserved_q == RES_W'(rowf_pkg::FIFO_DEPTH));
	assign acc      = in_valid && !in_stall;
	assign pop      = out_valid && !out_stall;

	// position of the current pixel and where the next one lands
	always_comb begin
		cur_col  = frame_start ? '0 : col_q;
		cur_row  = frame_start ? '0 : row_q;
		cur_slot = frame_start ? '0 : slot_q;
		col_inc  = LIM_W'(cur_col) + LIM_W'(1);
		row_inc  = 12'(cur_row) + 12'd1;
		col_wrap = (col_inc >= w_eff);
		row_wrap = (row_inc >= h_eff);

		tag.keep = (cur_row >= ROW_W'(WINDOW - 1)) && (cur_col >= COL_W'(WINDOW - 1)) &&
			(12'(cur_row) < h_eff) && (LIM_W'(cur_col) < w_eff);
		tag.frame_end = (12'(cur_row) == h_eff - 12'd1) &&
			(LIM_W'(cur_col) == w_eff - LIM_W'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			slot_q <= '0;
		end else if (acc) begin
			if (col_wrap) begin
				col_q <= '0;
				if (row_wrap) begin
					row_q  <= '0;
					slot_q <= '0;
				end else begin
					row_q  <= row_inc[ROW_W-1:0];
					slot_q <= (cur_slot == SLOT_W'(WINDOW - 1)) ? '0 : cur_slot + SLOT_W'(1);
				end
			end else begin
				col_q  <= col_inc[COL_W-1:0];
				row_q  <= cur_row;
				slot_q <= cur_slot;
			end
		end
	end

	// one queue slot reserved per result still in the pipe or queued
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reserved_q <= '0;
		end else begin
			case ({acc && tag.keep, pop})
				2'b10:   reserved_q <= reserved_q + RES_W'(1);
				2'b01:   reserved_q <= reserved_q - RES_W'(1);
				default: reserved_q <= reserved_q;
			endcase
		end
	end

	rowf_line_store #(
		.WINDOW    (WINDOW),
		.MAX_WIDTH (MAX_WIDTH)
	) u_line_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (acc),
		.addr      (cur_col),
		.slot      (cur_slot),
		.pix       (pixel),
		.tag       (tag),
		.col_valid (col_valid),
		.col_vec   (col_vec),
		.col_tag   (col_tag)
	);

	rowf_rank_unit #(
		.WINDOW (WINDOW)
	) u_rank_unit (
		.clk       (clk),
		.arst_n    (arst_n),
		.col_valid (col_valid),
		.col_vec   (col_vec),
		.col_tag   (col_tag),
		.rank_eff  (rank_eff),
		.mode      (filter_mode_q),
		.res_valid (res_valid),
		.res       (res)
	);

	rowf_out_fifo #(
		.DEPTH (rowf_pkg::FIFO_DEPTH)
	) u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.pop       (pop),
		.not_empty (out_valid),
		.head      (head)
	);

	assign value     = head.value;
	assign frame_end = head.frame_end;

`ifndef SYNTH
	a_reserve_bound: assert property (@(posedge clk) disable iff (!arst_n)
		reserved_q <= RES_W'(rowf_pkg::FIFO_DEPTH))
		else $error("reserved result count out of range");
	a_queued_reserved: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (reserved_q != '0))
		else $error("queued result without a reservation");
`endif

endmodule
